### rtl/bvrs_pkg.sv
// ----------------------------------------------------------------------------
// bvrs_pkg
// Shared widths, command and status codes, and the store control type for
// the bit vector rank/select core.
// ----------------------------------------------------------------------------
package bvrs_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 64;
    localparam int POS_W  = 16;
    localparam int VAL_W  = 17;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RANK1   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RANK0   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SELECT1 = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SELECT0 = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### rtl/bit_vector_rank_select_core.sv
// Clear, append and unused commands finish directly; rank reads one word and ends early
// when the position lies past the store. Select runs a binary search over the words,
// one memory read and compare per probe, then reads the found word and halves a window
// within it. One command at a time, so a command holds the core until it finishes; the
// next transfer is taken while a result waits. Synchronous active-low reset empties the
// store.
// ----------------------------------------------------------------------------
// bit_vector_rank_select_core
// Stores a bit vector as words with per-word prefix counts of ones and
// answers rank and select queries through a small sequencer that reuses
// one popcount unit, one compare/subtract and the single memory read port.
// ----------------------------------------------------------------------------
module bit_vector_rank_select_core #(
    parameter int MAX_WORDS = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bvrs_pkg::CMD_W-1:0]   i_command,
    input  logic [bvrs_pkg::DATA_W-1:0]  i_data_word,
    input  logic [bvrs_pkg::POS_W-1:0]   i_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bvrs_pkg::VAL_W-1:0]   o_value,
    output logic [bvrs_pkg::STAT_W-1:0]  o_status
);

    localparam int AW       = $clog2(MAX_WORDS > 1 ? MAX_WORDS : 2);
    localparam int HW       = $clog2(MAX_WORDS + 1);
    localparam int CNT_W    = $clog2(MAX_WORDS * WORD_BITS + 1);
    localparam int VW       = (CNT_W > bvrs_pkg::VAL_W) ? CNT_W : bvrs_pkg::VAL_W;
    localparam int LB       = $clog2(WORD_BITS);
    localparam int WP       = 1 << LB;
    localparam int PC_W     = $clog2(WP + 1);
    localparam int REM_W    = LB + 1;
    localparam int RECIP_SH = bvrs_pkg::POS_W + LB;
    localparam int RECIP_M  = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W  = bvrs_pkg::POS_W + 2;
    localparam int PROD_W   = bvrs_pkg::POS_W + RECIP_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_RANK_CHK = 4'd3;
    localparam logic [3:0] S_RANK_ACC = 4'd4;
    localparam logic [3:0] S_SRCH_RD  = 4'd5;
    localparam logic [3:0] S_SRCH_CMP = 4'd6;
    localparam logic [3:0] S_FIN_RD   = 4'd7;
    localparam logic [3:0] S_FIN_LOAD = 4'd8;
    localparam logic [3:0] S_INWORD   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]                     r_state;
    logic [bvrs_pkg::CMD_W-1:0]     r_cmd;
    logic [WORD_BITS-1:0]           r_data;
    logic [bvrs_pkg::POS_W-1:0]     r_pos;
    logic [HW-1:0]                  r_held;
    logic [VW-1:0]                  r_ones;
    logic [bvrs_pkg::POS_W-1:0]     r_quot;
    logic [REM_W-1:0]               r_rem;
    logic [HW-1:0]                  r_lo;
    logic [HW-1:0]                  r_hi;
    logic [HW-1:0]                  r_mid;
    logic [AW-1:0]                  r_idx;
    logic [WP-1:0]                  r_x;
    logic [VW-1:0]                  r_j;
    logic [VW-1:0]                  r_base;
    logic [LB-1:0]                  r_half;
    logic [bvrs_pkg::VAL_W-1:0]     r_res_value;
    logic [bvrs_pkg::STAT_W-1:0]    r_res_status;
    logic                           r_out_valid;
    logic [bvrs_pkg::VAL_W-1:0]     r_value;
    logic [bvrs_pkg::STAT_W-1:0]    r_status;

    bvrs_pkg::t_mem_ctl             mem_ctl;
    logic [AW-1:0]                  rd_addr;
    logic [WORD_BITS-1:0]           rd_word;
    logic [CNT_W-1:0]               rd_count;

    logic                           want_ones;
    logic                           store_full;
    logic [WP-1:0]                  pc_operand;
    logic [PC_W-1:0]                pc;
    logic [PROD_W-1:0]              div_prod;
    logic [bvrs_pkg::POS_W-1:0]     quot;
    logic [bvrs_pkg::POS_W-1:0]     rem_full;
    logic [WORD_BITS-1:0]           below;
    logic [WP-1:0]                  hmask;
    logic [VW-1:0]                  held_bits;
    logic [VW-1:0]                  total_sel;
    logic [HW:0]                    mid_sum;
    logic [HW-1:0]                  mid;
    logic [HW-1:0]                  cb_index;
    logic [VW-1:0]                  cb;
    logic [VW-1:0]                  rank_ones;
    logic                           take_high;
    logic [VW-1:0]                  base_next;

    function automatic logic [PC_W-1:0] popcount(input logic [WP-1:0] x);
        logic [PC_W-1:0] c;
        c = '0;
        for (int b = 0; b < WP; b++) begin
            c = c + PC_W'(x[b]);
        end
        return c;
    endfunction

    assign want_ones  = (r_cmd == bvrs_pkg::CMD_SELECT1);
    assign store_full = (r_held == HW'(MAX_WORDS));

    // The one popcount unit serves append, rank and the in-word select steps.
    always_comb begin
        unique case (r_state)
            S_EXEC:     pc_operand = WP'(r_data);
            S_RANK_ACC: pc_operand = WP'(rd_word & below);
            S_INWORD:   pc_operand = r_x & hmask;
            default:    pc_operand = '0;
        endcase
    end
    assign pc = popcount(pc_operand);

    // The word index comes from a multiply by the scaled reciprocal of the word
    // size, which is exact over the whole position range.
    assign div_prod = PROD_W'(r_pos) * PROD_W'(RECIP_M);
    assign quot     = bvrs_pkg::POS_W'(div_prod >> RECIP_SH);
    assign rem_full = r_pos - r_quot * bvrs_pkg::POS_W'(WORD_BITS);

    assign below = ~({WORD_BITS{1'b1}} << r_rem);
    assign hmask = ~({WP{1'b1}} << r_half);

    assign held_bits = VW'(r_held) * VW'(WORD_BITS);
    assign total_sel = want_ones ? r_ones : held_bits - r_ones;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[HW:1];

    // Ones or zeros in all words before the probed word.
    assign cb_index = (r_state == S_FIN_LOAD) ? HW'(r_idx) : r_mid;
    assign cb = want_ones ? VW'(rd_count)
                          : VW'(cb_index) * VW'(WORD_BITS) - VW'(rd_count);

    assign rank_ones = VW'(rd_count) + VW'(pc);
    assign take_high = (r_j >= VW'(pc));
    assign base_next = take_high ? r_base + VW'(r_half) : r_base;

    always_comb begin
        mem_ctl.wr_en = (r_state == S_EXEC) && (r_cmd == bvrs_pkg::CMD_APPEND)
                        && !store_full;
        mem_ctl.rd_en = (r_state == S_RANK_CHK) || (r_state == S_SRCH_RD)
                        || (r_state == S_FIN_RD);
        unique case (r_state)
            S_RANK_CHK: rd_addr = r_quot[AW-1:0];
            S_SRCH_RD:  rd_addr = mid[AW-1:0];
            default:    rd_addr = r_idx;
        endcase
    end

    bvrs_store #(
        .DEPTH  (MAX_WORDS),
        .WORD_W (WORD_BITS),
        .CNT_W  (CNT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_wr_addr  (r_held[AW-1:0]),
        .i_wr_word  (r_data),
        .i_wr_count (CNT_W'(r_ones)),
        .i_rd_addr  (rd_addr),
        .o_rd_word  (rd_word),
        .o_rd_count (rd_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_ones      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_command;
                        r_data  <= i_data_word[WORD_BITS-1:0];
                        r_pos   <= i_position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_value <= '0;
                    case (r_cmd) inside
                        bvrs_pkg::CMD_CLEAR: begin
                            r_held       <= '0;
                            r_ones       <= '0;
                            r_res_status <= bvrs_pkg::ST_OK;
                            r_state      <= S_DONE;
                        end
                        bvrs_pkg::CMD_APPEND: begin
                            r_state <= S_DONE;
                            if (store_full) begin
                                r_res_status <= bvrs_pkg::ST_FULL;
                            end else begin
                                r_res_status <= bvrs_pkg::ST_OK;
                                r_ones       <= r_ones + VW'(pc);
                                r_held       <= r_held + HW'(1);
                            end
                        end
                        bvrs_pkg::CMD_RANK1, bvrs_pkg::CMD_RANK0: begin
                            r_res_status <= bvrs_pkg::ST_OK;
                            r_quot       <= quot;
                            r_state      <= S_RANK_CHK;
                        end
                        bvrs_pkg::CMD_SELECT1, bvrs_pkg::CMD_SELECT0: begin
                            if (r_held == '0 || VW'(r_pos) >= total_sel) begin
                                r_res_status <= bvrs_pkg::ST_RANGE;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= bvrs_pkg::ST_OK;
                                r_lo         <= '0;
                                r_hi         <= r_held;
                                r_state      <= S_SRCH_RD;
                            end
                        end
                        default: begin
                            r_res_status <= bvrs_pkg::ST_OK;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                S_RANK_CHK: begin
                    // The word read is issued here and used only when in range.
                    r_rem <= REM_W'(rem_full);
                    if (32'(r_quot) >= 32'(r_held)) begin
                        r_res_value  <= '0;
                        r_res_status <= bvrs_pkg::ST_RANGE;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_RANK_ACC;
                    end
                end
                S_RANK_ACC: begin
                    r_res_value  <= (r_cmd == bvrs_pkg::CMD_RANK1)
                                    ? bvrs_pkg::VAL_W'(rank_ones)
                                    : bvrs_pkg::VAL_W'(VW'(r_pos) - rank_ones);
                    r_res_status <= bvrs_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                S_SRCH_RD: begin
                    // The first word always has a zero count before it, so the
                    // search ends with lo of at least one.
                    if (r_lo == r_hi) begin
                        r_idx   <= AW'(r_lo - HW'(1));
                        r_state <= S_FIN_RD;
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (cb <= VW'(r_pos)) begin
                        r_lo <= r_mid + HW'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SRCH_RD;
                end
                S_FIN_RD: begin
                    r_state <= S_FIN_LOAD;
                end
                S_FIN_LOAD: begin
                    r_x     <= want_ones ? WP'(rd_word) : WP'(~rd_word);
                    r_j     <= VW'(r_pos) - cb;
                    r_base  <= '0;
                    r_half  <= LB'(WP / 2);
                    r_state <= S_INWORD;
                end
                S_INWORD: begin
                    // Halve the window each step, keeping the half that holds
                    // the wanted bit.
                    if (take_high) begin
                        r_x <= r_x >> r_half;
                        r_j <= r_j - VW'(pc);
                    end
                    r_base <= base_next;
                    r_half <= r_half >> 1;
                    if (r_half == LB'(1)) begin
                        r_res_value  <= bvrs_pkg::VAL_W'(VW'(r_idx) * VW'(WORD_BITS)
                                                         + base_next);
                        r_res_status <= bvrs_pkg::ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_value  <= r_res_value;
            r_status <= r_res_status;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

### rtl/bvrs_store.sv
// ----------------------------------------------------------------------------
// bvrs_store
// Word memory and prefix count memory sharing one write and one read
// address, with registered read data.
// ----------------------------------------------------------------------------
module bvrs_store #(
    parameter int DEPTH  = 1024,
    parameter int WORD_W = 64,
    parameter int CNT_W  = 17
) (
    input  logic                     i_clk,
    input  bvrs_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]        i_wr_word,
    input  logic [CNT_W-1:0]         i_wr_count,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WORD_W-1:0]        o_rd_word,
    output logic [CNT_W-1:0]         o_rd_count
);

    logic [WORD_W-1:0] r_words  [DEPTH];
    logic [CNT_W-1:0]  r_counts [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_words[i_wr_addr]  <= i_wr_word;
            r_counts[i_wr_addr] <= i_wr_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_word  <= r_words[i_rd_addr];
            o_rd_count <= r_counts[i_rd_addr];
        end
    end

endmodule

### rtl/bvrs_checker.sv
// ----------------------------------------------------------------------------
// bvrs_checker
// Port-level checks on the rank/select core, attached by bind.
// ----------------------------------------------------------------------------
module bvrs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [bvrs_pkg::VAL_W-1:0]   o_value,
    input logic [bvrs_pkg::STAT_W-1:0]  o_status
);

    logic [1:0] r_outstanding;

    // Commands taken whose result has not yet been transferred out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 2'(i_valid && o_ready)
                             - 2'(o_valid && i_ready);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("stalled result changed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bvrs_pkg::ST_OK |-> o_value == '0)
        else $error("nonzero value with error status");

    a_one_result_each: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding <= 2'd2) && (!o_valid || r_outstanding != 2'd0))
        else $error("result without a matching command");

endmodule

bind bit_vector_rank_select_core bvrs_checker u_bvrs_checker (.*);

### dv/bit_vector_rank_select_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_vector_rank_select_core_test
// Drives clear, append, rank and select commands into the core through its
// valid/ready channels with bursty input and a stalling output side. A
// shadow copy of the word and prefix-count stores predicts every result not
// fixed in the opening rows, and results are compared field by field in transfer order.
// ----------------------------------------------------------------------------
module bit_vector_rank_select_core_test;

    localparam int MAX_WORDS   = 1024;
    localparam int WORD_BITS   = 64;
    localparam int N_ROWS      = 25;
    localparam int RAND_ITEMS  = 370;
    localparam int CYCLE_LIMIT = 200000;

    // Command codes the core treats as no-ops.
    localparam logic [bvrs_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [bvrs_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic [bvrs_pkg::DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [bvrs_pkg::CMD_W-1:0]  cmd;
        logic [bvrs_pkg::DATA_W-1:0] data;
        logic [bvrs_pkg::POS_W-1:0]  pos;
        logic                        fixed;
        logic [bvrs_pkg::VAL_W-1:0]  val;
        logic [bvrs_pkg::STAT_W-1:0] stat;
    } t_opening_row;

    typedef struct {
        logic [bvrs_pkg::CMD_W-1:0]  cmd;
        logic [bvrs_pkg::VAL_W-1:0]  val;
        logic [bvrs_pkg::STAT_W-1:0] stat;
    } t_answer;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_SQUARE} t_ready_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [bvrs_pkg::CMD_W-1:0]    i_command;
    logic [bvrs_pkg::DATA_W-1:0]   i_data_word;
    logic [bvrs_pkg::POS_W-1:0]    i_position;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [bvrs_pkg::VAL_W-1:0]    o_value;
    logic [bvrs_pkg::STAT_W-1:0]   o_status;

    // Shadow of the core's stores, updated at each accepted transfer.
    logic [bvrs_pkg::DATA_W-1:0]   shadow_words  [MAX_WORDS];
    logic [bvrs_pkg::VAL_W-1:0]    shadow_prefix [MAX_WORDS];
    int unsigned                   held_words = 0;
    int unsigned                   ones_total = 0;

    t_answer                       pending_answers [$];
    t_opening_row                  opening_rows [N_ROWS];

    int unsigned                   sent_items      = 0;
    int unsigned                   results_checked = 0;
    int unsigned                   mismatch_count  = 0;
    int unsigned                   cycle_count     = 0;
    int unsigned                   burst_left      = 0;
    int unsigned                   mode_left       = 0;
    int unsigned                   hold_cnt        = 0;
    t_ready_mode                   ready_mode      = RDY_ALWAYS;

    bit_vector_rank_select_core #(
        .MAX_WORDS(MAX_WORDS),
        .WORD_BITS(WORD_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_data_word(i_data_word),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value),
        .o_status   (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned ones_before_word(input int unsigned m,
                                                     input bit want_ones);
        return want_ones ? shadow_prefix[m] : m * WORD_BITS - shadow_prefix[m];
    endfunction

    function automatic int unsigned nth_set_bit(input logic [bvrs_pkg::DATA_W-1:0] w,
                                                input int unsigned n);
        int unsigned left;
        left = n;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (w[b]) begin
                if (left == 0)
                    return b;
                left--;
            end
        end
        return 0;
    endfunction

    // Applies one command to the shadow stores and returns the answer it gives.
    function automatic void predict_answer(input logic [bvrs_pkg::CMD_W-1:0] cmd,
                                           input logic [bvrs_pkg::DATA_W-1:0] data,
                                           input logic [bvrs_pkg::POS_W-1:0] pos,
                                           output logic [bvrs_pkg::VAL_W-1:0] val,
                                           output logic [bvrs_pkg::STAT_W-1:0] stat);
        int unsigned widx, bit_off, ones, total, lo, hi, mid, idx, result;
        logic [bvrs_pkg::DATA_W-1:0] sel_word;
        bit want_ones;
        result = 0;
        stat = bvrs_pkg::ST_OK;
        case (cmd) inside
            bvrs_pkg::CMD_CLEAR: begin
                held_words = 0;
                ones_total = 0;
            end
            bvrs_pkg::CMD_APPEND: begin
                if (held_words >= MAX_WORDS) begin
                    stat = bvrs_pkg::ST_FULL;
                end else begin
                    shadow_words[held_words]  = data;
                    shadow_prefix[held_words] = ones_total[bvrs_pkg::VAL_W-1:0];
                    ones_total += $countones(data);
                    held_words++;
                end
            end
            bvrs_pkg::CMD_RANK1, bvrs_pkg::CMD_RANK0: begin
                widx    = pos / WORD_BITS;
                bit_off = pos % WORD_BITS;
                if (widx >= held_words) begin
                    stat = bvrs_pkg::ST_RANGE;
                end else begin
                    ones = shadow_prefix[widx] +
                           $countones(shadow_words[widx] & ((64'd1 << bit_off) - 64'd1));
                    result = (cmd == bvrs_pkg::CMD_RANK1) ? ones : pos - ones;
                end
            end
            bvrs_pkg::CMD_SELECT1, bvrs_pkg::CMD_SELECT0: begin
                want_ones = (cmd == bvrs_pkg::CMD_SELECT1);
                total = want_ones ? ones_total : held_words * WORD_BITS - ones_total;
                if (held_words == 0 || pos >= total) begin
                    stat = bvrs_pkg::ST_RANGE;
                end else begin
                    // Find the last word whose preceding count does not exceed pos.
                    lo = 0;
                    hi = held_words;
                    while (lo != hi) begin
                        mid = (lo + hi) / 2;
                        if (ones_before_word(mid, want_ones) <= pos)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    idx = lo - 1;
                    sel_word = want_ones ? shadow_words[idx] : ~shadow_words[idx];
                    result = idx * WORD_BITS +
                             nth_set_bit(sel_word, pos - ones_before_word(idx, want_ones));
                end
            end
            default: ;
        endcase
        val = result[bvrs_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [bvrs_pkg::DATA_W-1:0] fresh_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [bvrs_pkg::POS_W-1:0] rand_pos();
        return bvrs_pkg::POS_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Words with a spread of densities so that selects land in varied places.
    function automatic logic [bvrs_pkg::DATA_W-1:0] pattern_word();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return fresh_word() & fresh_word() & fresh_word();
            3:       return fresh_word() | fresh_word() | fresh_word();
            4:       return 64'd1 << $urandom_range(0, WORD_BITS - 1);
            default: return fresh_word();
        endcase
    endfunction

    // Presents one command and returns at the edge where it is transferred.
    task automatic drive_command(input logic [bvrs_pkg::CMD_W-1:0] cmd,
                                 input logic [bvrs_pkg::DATA_W-1:0] data,
                                 input logic [bvrs_pkg::POS_W-1:0] pos,
                                 input logic fixed,
                                 input logic [bvrs_pkg::VAL_W-1:0] val,
                                 input logic [bvrs_pkg::STAT_W-1:0] stat);
        int unsigned gap;
        t_answer ans;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_data_word <= data;
        i_position  <= pos;
        do @(posedge i_clk); while (!o_ready);
        ans.cmd = cmd;
        predict_answer(cmd, data, pos, ans.val, ans.stat);
        if (fixed) begin
            ans.val  = val;
            ans.stat = stat;
        end
        pending_answers.push_back(ans);
        sent_items++;
    endtask

    task automatic issue(input logic [bvrs_pkg::CMD_W-1:0] cmd,
                         input logic [bvrs_pkg::DATA_W-1:0] data,
                         input logic [bvrs_pkg::POS_W-1:0] pos);
        drive_command(cmd, data, pos, 1'b0, '0, bvrs_pkg::ST_OK);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly in-range ranks and selects, with edges of the range and some noise.
    task automatic random_query();
        int unsigned pick, total, k;
        logic [bvrs_pkg::CMD_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            cmd = $urandom_range(0, 1) ? bvrs_pkg::CMD_RANK1 : bvrs_pkg::CMD_RANK0;
            k = $urandom_range(0, held_words * WORD_BITS + 8);
            if (k > 16'hFFFF)
                k = 16'hFFFF;
            issue(cmd, fresh_word(), k[bvrs_pkg::POS_W-1:0]);
        end else if (pick < 80) begin
            cmd = $urandom_range(0, 1) ? bvrs_pkg::CMD_SELECT1 : bvrs_pkg::CMD_SELECT0;
            total = (cmd == bvrs_pkg::CMD_SELECT1) ? ones_total
                                                   : held_words * WORD_BITS - ones_total;
            case ($urandom_range(0, 4))
                0:       k = (total == 0) ? 0 : total - 1;
                1:       k = total;
                default: k = $urandom_range(0, total + 2);
            endcase
            if (k > 16'hFFFF)
                k = 16'hFFFF;
            issue(cmd, fresh_word(), k[bvrs_pkg::POS_W-1:0]);
        end else if (pick < 90) begin
            issue(bvrs_pkg::CMD_APPEND, pattern_word(), rand_pos());
        end else if (pick < 96) begin
            issue(bvrs_pkg::CMD_W'($urandom_range(0, 7)), fresh_word(), rand_pos());
        end else begin
            issue($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, fresh_word(),
                  rand_pos());
        end
    endtask

    // The output side switches at random between stall patterns.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (mode_left == 0) begin
            mode_left  <= $urandom_range(32, 256);
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: i_ready <= 1'b1;
            RDY_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: begin
                if (hold_cnt == 0) begin
                    i_ready  <= 1'b1;
                    hold_cnt <= $urandom_range(1, 10);
                end else begin
                    i_ready  <= 1'b0;
                    hold_cnt <= hold_cnt - 1;
                end
            end
            default:    i_ready <= cycle_count[2];
        endcase
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_answer ans;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result with none expected: value %0d, status %0d", o_value, o_status);
                mismatch_count++;
            end else begin
                ans = pending_answers.pop_front();
                results_checked++;
                if (o_value !== ans.val) begin
                    $error("value (command %0d): expected %0d, actual %0d",
                           ans.cmd, ans.val, o_value);
                    mismatch_count++;
                end
                if (o_status !== ans.stat) begin
                    $error("status (command %0d): expected %0d, actual %0d",
                           ans.cmd, ans.stat, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned target;
        int unsigned n;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = bvrs_pkg::CMD_CLEAR;
        i_data_word = '0;
        i_position  = '0;

        // Three words: all ones, all zeros, then ones at both ends.
        opening_rows = '{
            '{bvrs_pkg::CMD_RANK1,   64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_SELECT1, 64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_SELECT0, ALL_ONES, 16'hFFFF, 1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{CMD_SPARE_A,           ALL_ONES, 16'hFFFF, 1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{CMD_SPARE_B,           64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_APPEND,  ALL_ONES, 16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_APPEND,  64'h0,    16'hFFFF, 1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_APPEND,  64'h8000_0000_0000_0001, 16'd0, 1'b1, 17'd0,
              bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_RANK1,   64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_RANK1,   64'h0,    16'd64,   1'b1, 17'd64, bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_RANK0,   64'h0,    16'd191,  1'b0, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_RANK1,   64'h0,    16'd192,  1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_SELECT1, 64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT1, 64'h0,    16'd63,   1'b1, 17'd63, bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT1, 64'h0,    16'd64,   1'b0, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT1, 64'h0,    16'd65,   1'b0, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT1, 64'h0,    16'd66,   1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_SELECT0, 64'h0,    16'd0,    1'b1, 17'd64, bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT0, 64'h0,    16'd125,  1'b0, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT0, 64'h0,    16'd126,  1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_RANK1,   64'h0,    16'hFFFF, 1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_CLEAR,   64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_SELECT0, 64'h0,    16'd0,    1'b1, 17'd0,  bvrs_pkg::ST_RANGE},
            '{bvrs_pkg::CMD_APPEND,  64'h0123_4567_89AB_CDEF, 16'd0, 1'b1, 17'd0,
              bvrs_pkg::ST_OK},
            '{bvrs_pkg::CMD_RANK0,   64'h0,    16'd63,   1'b0, 17'd0,  bvrs_pkg::ST_OK}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[r])
            drive_command(opening_rows[r].cmd, opening_rows[r].data, opening_rows[r].pos,
                          opening_rows[r].fixed, opening_rows[r].val, opening_rows[r].stat);

        // Each episode builds a short vector and then queries it.
        target = sent_items + RAND_ITEMS;
        while (sent_items < target) begin
            if ($urandom_range(0, 9) == 0)
                drain_results();
            if ($urandom_range(0, 4) != 0)
                issue(bvrs_pkg::CMD_CLEAR, fresh_word(), rand_pos());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            repeat (n)
                issue(bvrs_pkg::CMD_APPEND, pattern_word(), rand_pos());
            n = $urandom_range(8, 30);
            repeat (n)
                random_query();
        end

        // Let the core go fully idle before the closing queries.
        drain_results();

        issue(bvrs_pkg::CMD_RANK1, fresh_word(), 16'hFFFF);
        issue(bvrs_pkg::CMD_SELECT1, fresh_word(), 16'hFFFF);
        issue(bvrs_pkg::CMD_SELECT0, fresh_word(), 16'd0);
        repeat (20)
            random_query();

        drain_results();
        repeat (60) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results, with bursty input and stalled output.",
                 sent_items, results_checked);
        $display("Rank and select of both kinds ran on empty and short stores, range edges included.");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
